// ===== rtl/core/per_slot_counter_bank_macros.svh =====
// Assertion macros shared by the counter bank checker.
// No dependencies; included by files that assert.
`ifndef PER_SLOT_COUNTER_BANK_MACROS_SVH
`define PER_SLOT_COUNTER_BANK_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PSCB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define PSCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pscb_pkg.sv =====
// Constants for the per-slot counter bank: sizes, widths and operation codes.
// No dependencies.
`default_nettype none

package pscb_pkg;

   localparam int MAX_SLOTS    = 16;
   localparam int METRIC_COUNT = 32;
   localparam int DEPTH        = MAX_SLOTS * METRIC_COUNT;
   localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W        = $clog2(MAX_SLOTS + 1);
   localparam int IDX_W        = 9;

   localparam int KIND_W       = 2;
   localparam int SLOT_W       = 8;
   localparam int METRIC_W     = 8;
   localparam int DATA_W       = 64;
   localparam int CSR_DATA_W   = 5;
   localparam int CSR_IDX_W    = 1;

   localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUM = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS   = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/per_slot_counter_bank.sv =====
// Per-slot counter bank: 64-bit counters in one synchronous RAM.
// Depends on pscb_pkg.
//
// Counters are indexed by slot * METRIC_COUNT + metric and live in a single-port-write,
// one-read RAM with a registered read. After reset the block stalls requests while
// it zeroes all DEPTH (512) RAM entries; csr writes are taken throughout.
// An add or set occupies the block through accept, read and write back; ignored
// items are dropped at accept. A sum query walks the slots in use one RAM read per
// cycle and goes through accept, reads and accumulation over the effective slot
// count, and result load, which waits for the output register to free up; a sum that
// is disabled or has its metric out of range skips the reads and loads a zero result.
// One item is in flight at a time; a finished sum may sit in the output register while
// the next request is accepted.
`default_nettype none

module per_slot_counter_bank (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [pscb_pkg::KIND_W-1:0]         req_kind,
   input  wire logic [pscb_pkg::SLOT_W-1:0]         req_slot,
   input  wire logic [pscb_pkg::METRIC_W-1:0]       req_metric_index,
   input  wire logic [pscb_pkg::DATA_W-1:0]         req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [pscb_pkg::DATA_W-1:0]              rsp_total,
   input  wire logic                                csr_wr_en,
   input  wire logic [pscb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pscb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = pscb_pkg::ADDR_W;
   localparam int CW = pscb_pkg::CNT_W;
   localparam int IW = pscb_pkg::IDX_W;
   localparam int DW = pscb_pkg::DATA_W;

   localparam logic [AW-1:0] LAST_ADDR    = AW'(pscb_pkg::DEPTH - 1);
   localparam logic [AW-1:0] MC_ADDR      = AW'(pscb_pkg::METRIC_COUNT);
   localparam logic [AW:0]   MC_STEP      = (AW + 1)'(pscb_pkg::METRIC_COUNT);
   localparam logic [IW-1:0] METRIC_LIMIT = IW'(pscb_pkg::METRIC_COUNT);
   localparam logic [IW-1:0] SLOT_LIMIT   = IW'(pscb_pkg::MAX_SLOTS);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_WRITE = 6'b001000,
      ST_SUM   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic               enabled_ff, enabled_in;
   logic [pscb_pkg::CSR_DATA_W-1:0] slots_ff, slots_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               is_set_ff, is_set_in;
   logic [DW-1:0]      value_ff, value_in;
   logic [DW-1:0]      acc_ff, acc_in;
   logic [CW-1:0]      eff_ff, eff_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]      rsp_total_ff, rsp_total_in;

   logic [DW-1:0]      mem [pscb_pkg::DEPTH];
   logic [DW-1:0]      rd_data_ff;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [DW-1:0]      mem_wr_data;

   logic [IW-1:0]      eff_raw;
   logic [IW-1:0]      eff_slots;
   logic               metric_ok;
   logic               slot_ok;
   logic               accept;
   logic               out_free;
   logic [AW-1:0]      slot_addr;
   logic [AW-1:0]      item_addr;

   always_comb begin
      eff_raw = IW'(slots_ff);
      if (eff_raw == '0) begin
         eff_slots = IW'(1);
      end else if (eff_raw > SLOT_LIMIT) begin
         eff_slots = SLOT_LIMIT;
      end else begin
         eff_slots = eff_raw;
      end
   end

   assign metric_ok = IW'(req_metric_index) < METRIC_LIMIT;
   assign slot_ok   = IW'(req_slot) < eff_slots;
   assign slot_addr = AW'(req_slot);
   assign item_addr = AW'(slot_addr * MC_ADDR) + AW'(req_metric_index);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      enabled_in   = enabled_ff;
      slots_in     = slots_ff;
      state_in     = state_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      is_set_in    = is_set_ff;
      value_in     = value_ff;
      acc_in       = acc_ff;
      eff_in       = eff_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_total_in = rsp_total_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = addr_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = addr_ff;
      mem_wr_data  = value_ff;

      if (csr_wr_en) begin
         case (csr_index)
            pscb_pkg::CSR_ENABLED: enabled_in = csr_wdata[0];
            pscb_pkg::CSR_SLOTS:   slots_in   = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               is_set_in = (req_kind == pscb_pkg::KIND_SET);
               value_in  = req_value;
               eff_in    = CW'(eff_slots);
               issue_in  = '0;
               acc_in    = '0;
               case (req_kind)
                  pscb_pkg::KIND_ADD,
                  pscb_pkg::KIND_SET: begin
                     addr_in = item_addr;
                     if (enabled_ff && metric_ok && slot_ok) begin
                        state_in = ST_READ;
                     end
                  end
                  pscb_pkg::KIND_SUM: begin
                     addr_in = AW'(req_metric_index);
                     if (enabled_ff && metric_ok) begin
                        state_in = ST_SUM;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = is_set_ff ? value_ff : rd_data_ff + value_ff;
            state_in    = ST_IDLE;
         end
         ST_SUM: begin
            if (issue_ff != eff_ff) begin
               mem_rd_en = 1'b1;
               pend_in   = 1'b1;
               issue_in  = issue_ff + CW'(1);
               addr_in   = AW'({1'b0, addr_ff} + MC_STEP);
            end
            if (pend_ff) begin
               acc_in = acc_ff + rd_data_ff;
            end
            if (pend_ff && (issue_ff == eff_ff)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         enabled_ff   <= 1'b0;
         slots_ff     <= pscb_pkg::CSR_DATA_W'(1);
         clr_ff       <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         slots_ff     <= slots_in;
         clr_ff       <= clr_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      is_set_ff    <= is_set_in;
      value_ff     <= value_in;
      acc_ff       <= acc_in;
      eff_ff       <= eff_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_total = rsp_total_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pscb_checker.sv =====
// Port-level checker for the per-slot counter bank, bound into per_slot_counter_bank.
// Depends on pscb_pkg and per_slot_counter_bank_macros.svh.
`default_nettype none

`include "per_slot_counter_bank_macros.svh"

module pscb_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic [pscb_pkg::KIND_W-1:0]       req_kind,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [pscb_pkg::DATA_W-1:0]       rsp_total
);

   // stalled result holds
   `PSCB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_total), "rsp payload changed while stalled")

   // RAM clear pass blocks requests right after reset
   `PSCB_ASSERT_NOW(a_clear_stall, clock, reset, $past(reset), req_stall, "request taken during clear pass")

   // a sum transfer keeps the block busy until its result is loaded
   `PSCB_ASSERT_NEXT(a_sum_busy, clock, reset, req_valid && !req_stall && (req_kind == pscb_pkg::KIND_SUM), req_stall, "request taken while sum in flight")

   // no result appears out of reset
   `PSCB_ASSERT_NOW(a_rst_quiet, clock, reset, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind per_slot_counter_bank pscb_checker u_pscb_checker (.*);

`default_nettype wire
